### rtl/string_to_integer_parser_assert.svh
// Assertion macros for the string to integer parser checker.
// Depends on nothing; the including module supplies clk and rst.
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define STIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define STIP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/stip_pkg.sv
// Package for the string to integer parser: payload types, character codes,
// radix constants and the digit decoder. Depends on nothing.
package stip_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int POSITION_WIDTH = 16;
  localparam int BASE_WIDTH     = 6;
  localparam int CHAR_WIDTH     = 8;

  localparam logic [VALUE_WIDTH-1:0] VALUE_HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [POSITION_WIDTH-1:0] POSITION_MAX = '1;

  localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_RESET = BASE_DEC;

  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] LETTER_OFFSET = 8'd10;

  typedef struct packed {
    logic                  first_char;
    logic [CHAR_WIDTH-1:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          range_error;
    logic                          digits_found;
    logic [POSITION_WIDTH-1:0]     end_offset;
  } out_word_t;

  typedef struct packed {
    logic                  alnum;
    logic [BASE_WIDTH-1:0] digit;
  } digit_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_LEAD   = 5'b00010,
    PH_SIGNED = 5'b00100,
    PH_ZERO   = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  function automatic digit_t decode_digit(input logic [CHAR_WIDTH-1:0] c);
    digit_t r;
    logic [CHAR_WIDTH-1:0] d;
    r = '0;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r.alnum = 1'b1;
      d = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r.alnum = 1'b1;
      d = c - CH_UP_A + LETTER_OFFSET;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      r.alnum = 1'b1;
      d = c - CH_LO_A + LETTER_OFFSET;
    end
    r.digit = d[BASE_WIDTH-1:0];
    return r;
  endfunction

endpackage

### rtl/string_to_integer_parser.sv
// String to integer parser top level: input register, one pass of parse logic,
// result register. Depends on stip_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid, in_stall   | first_char, char_code
//   out      | out_valid, out_stall | value, range_error, digits_found, end_offset
//   cfg      | cfg_we               | number_base
//
// One character is taken in every cycle unless in_stall holds the input. A result
// is shown on the output after its terminating character is taken: the character
// is held in the input register, then the parse logic with its multiply-accumulate
// and limit compare loads the result register.
// Reset is synchronous and sets the radix to ten and the parser to idle.
// A held result stalls only characters that would end another number.
module string_to_integer_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  stip_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output stip_pkg::out_word_t                out_data,
  input  logic                               cfg_we,
  input  logic [stip_pkg::BASE_WIDTH-1:0]    cfg_wdata
);

  localparam int VW = stip_pkg::VALUE_WIDTH;
  localparam int PW = stip_pkg::POSITION_WIDTH;
  localparam int BW = stip_pkg::BASE_WIDTH;
  localparam int MW = VW + BW + 1;

  logic [BW-1:0]       number_base;
  logic                s1_valid;
  stip_pkg::in_word_t  s1_data;

  stip_pkg::phase_t    phase, phase_next;
  logic                negative, negative_next;
  logic [VW-1:0]       accum, accum_next;
  logic                overflowed, overflowed_next;
  logic                any_digit, any_digit_next;
  logic [PW-1:0]       position, position_next;
  logic [BW-1:0]       active_base, active_base_next;

  logic                fire;
  logic                emit;
  logic                start;
  logic                take;
  logic                is_digit;
  logic [PW-1:0]       result_pos;
  stip_pkg::digit_t    dec;
  logic [MW-1:0]       product;
  logic [MW-1:0]       limit;
  logic [7:0]          c;

  always_comb begin
    c                = s1_data.char_code;
    dec              = stip_pkg::decode_digit(c);
    phase_next       = phase;
    negative_next    = negative;
    accum_next       = accum;
    overflowed_next  = overflowed;
    any_digit_next   = any_digit;
    position_next    = position;
    active_base_next = active_base;
    start            = 1'b0;
    take             = 1'b0;
    emit             = 1'b0;
    is_digit         = 1'b0;
    product          = '0;
    limit            = '0;

    if (s1_data.first_char) begin
      phase_next       = stip_pkg::PH_LEAD;
      negative_next    = 1'b0;
      accum_next       = '0;
      overflowed_next  = 1'b0;
      any_digit_next   = 1'b0;
      position_next    = '0;
      active_base_next = number_base;
    end

    case (phase_next)
      stip_pkg::PH_LEAD: begin
        if (c == stip_pkg::CH_SPACE || (c >= stip_pkg::CH_TAB && c <= stip_pkg::CH_CR)) begin
          phase_next = stip_pkg::PH_LEAD;
        end else if (c == stip_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = stip_pkg::PH_SIGNED;
        end else if (c == stip_pkg::CH_PLUS) begin
          phase_next = stip_pkg::PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      stip_pkg::PH_SIGNED: begin
        start = 1'b1;
      end
      stip_pkg::PH_ZERO: begin
        phase_next = stip_pkg::PH_DIGITS;
        if (c == stip_pkg::CH_LO_X || c == stip_pkg::CH_UP_X) begin
          active_base_next = stip_pkg::BASE_HEX;
        end else begin
          active_base_next = (active_base_next == stip_pkg::BASE_AUTO) ?
                             stip_pkg::BASE_OCT : stip_pkg::BASE_HEX;
          any_digit_next   = 1'b1;
          take             = 1'b1;
        end
      end
      stip_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next = stip_pkg::PH_IDLE;
      end
    endcase

    if (start) begin
      if ((active_base_next == stip_pkg::BASE_AUTO || active_base_next == stip_pkg::BASE_HEX)
          && c == stip_pkg::CH_ZERO) begin
        phase_next = stip_pkg::PH_ZERO;
      end else begin
        if (active_base_next == stip_pkg::BASE_AUTO) begin
          active_base_next = stip_pkg::BASE_DEC;
        end
        phase_next = stip_pkg::PH_DIGITS;
        take       = 1'b1;
      end
    end

    result_pos = position_next;

    if (take) begin
      is_digit = dec.alnum && (dec.digit < active_base_next) &&
                 (active_base_next != stip_pkg::BASE_AUTO);
      product  = MW'(accum_next) * MW'(active_base_next) + MW'(dec.digit);
      limit    = negative_next ? MW'(stip_pkg::VALUE_HALF) : MW'(stip_pkg::VALUE_MAX);
      if (is_digit) begin
        any_digit_next = 1'b1;
        if (!overflowed_next) begin
          if (product > limit) begin
            overflowed_next = 1'b1;
            accum_next      = limit[VW-1:0];
          end else begin
            accum_next = product[VW-1:0];
          end
        end
      end else begin
        emit       = 1'b1;
        phase_next = stip_pkg::PH_IDLE;
      end
    end

    if (phase_next != stip_pkg::PH_IDLE && position_next != stip_pkg::POSITION_MAX) begin
      position_next = position_next + 1'b1;
    end
  end

  assign fire     = s1_valid && (!emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= stip_pkg::BASE_RESET;
    end else if (cfg_we) begin
      number_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= stip_pkg::PH_IDLE;
      negative    <= 1'b0;
      accum       <= '0;
      overflowed  <= 1'b0;
      any_digit   <= 1'b0;
      position    <= '0;
      active_base <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      negative    <= negative_next;
      accum       <= accum_next;
      overflowed  <= overflowed_next;
      any_digit   <= any_digit_next;
      position    <= position_next;
      active_base <= active_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (fire && emit) || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data.value        <= negative_next ? (VW'(0) - accum_next) : accum_next;
      out_data.range_error  <= overflowed_next;
      out_data.digits_found <= any_digit_next;
      out_data.end_offset   <= any_digit_next ? result_pos : '0;
    end
  end

endmodule

### rtl/stip_checker.sv
// Port-level checker for the string to integer parser and its bind statement.
// Depends on stip_pkg and string_to_integer_parser_assert.svh.
`include "string_to_integer_parser_assert.svh"

module stip_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input stip_pkg::out_word_t out_data
);

  `STIP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "Stalled result changed.")
  `STIP_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "Result valid right after reset.")
  `STIP_ASSERT(a_no_digits, out_valid && !out_data.digits_found |-> out_data.value == 0 && out_data.end_offset == 0 && !out_data.range_error, "Empty number gave a nonzero result.")
  `STIP_ASSERT(a_digits_offset, out_valid && out_data.digits_found |-> out_data.end_offset != 0, "Number with digits ended at offset zero.")
  `STIP_ASSERT(a_saturate, out_valid && out_data.range_error |-> out_data.digits_found && (out_data.value == stip_pkg::VALUE_MAX || out_data.value == stip_pkg::VALUE_HALF), "Overflow result is not saturated.")

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/string_to_integer_parser_test.sv
// Self-checking bench for string_to_integer_parser: feeds character words, predicts
// every conversion result in the bench itself and compares it field by field.
// Depends on stip_pkg and the string_to_integer_parser RTL.
module string_to_integer_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS   = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 40;
  localparam int PRINT_LIMIT   = 40;
  localparam int FILL_DIGITS   = 40;

  localparam logic [stip_pkg::CHAR_WIDTH-1:0] CH_NUL  = 8'h00;
  localparam logic [stip_pkg::CHAR_WIDTH-1:0] CH_MARK = 8'h5E;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  stip_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  stip_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [stip_pkg::BASE_WIDTH-1:0] cfg_wdata = stip_pkg::BASE_RESET;

  string_to_integer_parser DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Conversion state of the bench's own parser.
  logic [stip_pkg::BASE_WIDTH-1:0]     base_setting = stip_pkg::BASE_RESET;
  logic [stip_pkg::BASE_WIDTH-1:0]     radix = stip_pkg::BASE_AUTO;
  stip_pkg::phase_t                    phase = stip_pkg::PH_IDLE;
  logic                                negative = 1'b0;
  longint unsigned                     magnitude = 0;
  logic                                saturated = 1'b0;
  logic                                seen_digit = 1'b0;
  logic [stip_pkg::POSITION_WIDTH-1:0] position = '0;

  stip_pkg::out_word_t results_due[$];
  int burst_left = 0;
  int words_sent = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int stall_pct = 0;
  int pattern_left = 0;
  longint cycle_count = 0;

  typedef struct {
    logic [stip_pkg::BASE_WIDTH-1:0] base;
    string                           text;
    int                              fill;
    bit                              typed;
    stip_pkg::out_word_t             want;
  } char_row_t;

  char_row_t directed_rows[$];

  function automatic stip_pkg::out_word_t number_result();
    stip_pkg::out_word_t r;
    logic [stip_pkg::VALUE_WIDTH-1:0] m;
    m = magnitude[stip_pkg::VALUE_WIDTH-1:0];
    r.value = negative ? -m : m;
    r.range_error = saturated;
    r.digits_found = seen_digit;
    r.end_offset = seen_digit ? position : '0;
    phase = stip_pkg::PH_IDLE;
    return r;
  endfunction

  function automatic bit add_digit(input logic [stip_pkg::CHAR_WIDTH-1:0] c,
                                   output stip_pkg::out_word_t r);
    logic [stip_pkg::CHAR_WIDTH-1:0] d;
    longint unsigned limit;
    if (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_NINE) begin
      d = c - stip_pkg::CH_ZERO;
    end else if (c >= stip_pkg::CH_UP_A && c <= stip_pkg::CH_UP_Z) begin
      d = c - stip_pkg::CH_UP_A + stip_pkg::LETTER_OFFSET;
    end else if (c >= stip_pkg::CH_LO_A && c <= stip_pkg::CH_LO_Z) begin
      d = c - stip_pkg::CH_LO_A + stip_pkg::LETTER_OFFSET;
    end else begin
      // Anything else is no digit in any radix the register can hold.
      d = '1;
    end
    if (d >= radix || radix == stip_pkg::BASE_AUTO) begin
      r = number_result();
      return 1'b1;
    end
    seen_digit = 1'b1;
    if (!saturated) begin
      limit = negative ? 64'(stip_pkg::VALUE_HALF) : 64'(stip_pkg::VALUE_MAX);
      if (magnitude > (limit - d) / radix) begin
        saturated = 1'b1;
        magnitude = limit;
      end else begin
        magnitude = magnitude * radix + d;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit start_number(input logic [stip_pkg::CHAR_WIDTH-1:0] c,
                                      output stip_pkg::out_word_t r);
    if ((radix == stip_pkg::BASE_AUTO || radix == stip_pkg::BASE_HEX) &&
        c == stip_pkg::CH_ZERO) begin
      phase = stip_pkg::PH_ZERO;
      return 1'b0;
    end
    if (radix == stip_pkg::BASE_AUTO) radix = stip_pkg::BASE_DEC;
    phase = stip_pkg::PH_DIGITS;
    return add_digit(c, r);
  endfunction

  function automatic bit parse_char(input logic first,
                                    input logic [stip_pkg::CHAR_WIDTH-1:0] c,
                                    output stip_pkg::out_word_t r);
    bit done;
    done = 1'b0;
    if (first) begin
      phase = stip_pkg::PH_LEAD;
      negative = 1'b0;
      magnitude = 0;
      saturated = 1'b0;
      seen_digit = 1'b0;
      position = '0;
      radix = base_setting;
    end else if (phase == stip_pkg::PH_IDLE) begin
      return 1'b0;
    end
    case (phase)
      stip_pkg::PH_LEAD: begin
        if (c == stip_pkg::CH_MINUS) begin
          negative = 1'b1;
          phase = stip_pkg::PH_SIGNED;
        end else if (c == stip_pkg::CH_PLUS) begin
          phase = stip_pkg::PH_SIGNED;
        end else if (c != stip_pkg::CH_SPACE &&
                     !(c >= stip_pkg::CH_TAB && c <= stip_pkg::CH_CR)) begin
          done = start_number(c, r);
        end
      end
      stip_pkg::PH_SIGNED: done = start_number(c, r);
      stip_pkg::PH_ZERO: begin
        phase = stip_pkg::PH_DIGITS;
        if (c == stip_pkg::CH_LO_X || c == stip_pkg::CH_UP_X) begin
          radix = stip_pkg::BASE_HEX;
        end else begin
          radix = (radix == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_OCT : stip_pkg::BASE_HEX;
          seen_digit = 1'b1;
          done = add_digit(c, r);
        end
      end
      stip_pkg::PH_DIGITS: done = add_digit(c, r);
      default: phase = stip_pkg::PH_IDLE;
    endcase
    if (phase != stip_pkg::PH_IDLE && position != stip_pkg::POSITION_MAX) position++;
    return done;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic send_char(input logic first, input logic [stip_pkg::CHAR_WIDTH-1:0] c,
                           input bit typed, input stip_pkg::out_word_t want);
    stip_pkg::out_word_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= stip_pkg::in_word_t'{first, c};
    do @(posedge clk); while (in_stall);
    burst_left--;
    words_sent++;
    if (parse_char(first, c, r)) results_due.push_back(typed ? want : r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [stip_pkg::BASE_WIDTH-1:0] b);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_setting = b;
  endtask

  function automatic void add_row(input logic [stip_pkg::BASE_WIDTH-1:0] b, input string text,
                                  input int fill, input bit typed,
                                  input stip_pkg::out_word_t want);
    char_row_t row;
    row.base = b;
    row.text = text;
    row.fill = fill;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic random_string();
    logic [stip_pkg::CHAR_WIDTH-1:0] chars[$];
    logic [stip_pkg::CHAR_WIDTH-1:0] d;
    int eff;
    int digits;
    int pick;
    bit nonzero_lead;
    nonzero_lead = 1'b0;
    eff = (base_setting > 36) ? 36 : int'(base_setting);
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_char($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      chars.push_back(($urandom_range(0, 1) == 0) ? stip_pkg::CH_SPACE :
                      8'(stip_pkg::CH_TAB + $urandom_range(0, 4)));
    end
    pick = $urandom_range(0, 3);
    if (pick == 0) chars.push_back(stip_pkg::CH_MINUS);
    else if (pick == 1) chars.push_back(stip_pkg::CH_PLUS);
    if (base_setting == stip_pkg::BASE_AUTO) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        chars.push_back(stip_pkg::CH_ZERO);
        chars.push_back(($urandom_range(0, 1) == 0) ? stip_pkg::CH_LO_X : stip_pkg::CH_UP_X);
        eff = 16;
      end else if (pick == 1) begin
        chars.push_back(stip_pkg::CH_ZERO);
        eff = 8;
      end else begin
        eff = 10;
        nonzero_lead = 1'b1;
      end
    end else if (base_setting == stip_pkg::BASE_HEX && $urandom_range(0, 1) == 0) begin
      chars.push_back(stip_pkg::CH_ZERO);
      chars.push_back(($urandom_range(0, 1) == 0) ? stip_pkg::CH_LO_X : stip_pkg::CH_UP_X);
    end
    digits = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    for (int i = 0; i < digits; i++) begin
      d = 8'($urandom_range(0, eff - 1));
      if (nonzero_lead && i == 0) d = 8'($urandom_range(1, 9));
      if (d < stip_pkg::LETTER_OFFSET) begin
        chars.push_back(stip_pkg::CH_ZERO + d);
      end else begin
        chars.push_back((($urandom_range(0, 1) == 0) ? stip_pkg::CH_LO_A : stip_pkg::CH_UP_A) +
                        d - stip_pkg::LETTER_OFFSET);
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      chars.push_back(($urandom_range(0, 1) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
    end
    foreach (chars[i]) send_char(i == 0, chars[i], 1'b0, '0);
  endtask

  always @(posedge clk) begin
    stip_pkg::out_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = results_due.pop_front();
          if (out_data.value !== want.value) begin
            report_mismatch($sformatf("value %0d, expected %0d", out_data.value, want.value));
          end
          if (out_data.range_error !== want.range_error) begin
            report_mismatch($sformatf("range_error %b, expected %b",
                                      out_data.range_error, want.range_error));
          end
          if (out_data.digits_found !== want.digits_found) begin
            report_mismatch($sformatf("digits_found %b, expected %b",
                                      out_data.digits_found, want.digits_found));
          end
          if (out_data.end_offset !== want.end_offset) begin
            report_mismatch($sformatf("end_offset %0d, expected %0d",
                                      out_data.end_offset, want.end_offset));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && results_seen >= HOLD_AFTER) begin
        // One long hold-off so that the parser backs up into its input.
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          stall_pct = $urandom_range(0, 2) * 40;
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        out_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    char_row_t row;
    logic flag_next;
    int phase_start;
    logic [stip_pkg::BASE_WIDTH-1:0] phase_bases[9];
    phase_bases = '{stip_pkg::BASE_AUTO, stip_pkg::BASE_HEX, 6'd36, stip_pkg::BASE_DEC, 6'd2,
                    6'd63, stip_pkg::BASE_OCT, 6'd1, 6'd0};
    phase_bases[8] = 6'($urandom_range(0, 63));

    add_row(stip_pkg::BASE_DEC, "^42", 0, 1'b1,
            stip_pkg::out_word_t'{32'sd42, 1'b0, 1'b1, 16'd2});
    add_row(stip_pkg::BASE_DEC, "^2147483647", 0, 1'b1,
            stip_pkg::out_word_t'{stip_pkg::VALUE_MAX, 1'b0, 1'b1, 16'd10});
    add_row(stip_pkg::BASE_DEC, "^-2147483648", 0, 1'b1,
            stip_pkg::out_word_t'{stip_pkg::VALUE_HALF, 1'b0, 1'b1, 16'd11});
    add_row(stip_pkg::BASE_DEC, "^2147483648", 0, 1'b1,
            stip_pkg::out_word_t'{stip_pkg::VALUE_MAX, 1'b1, 1'b1, 16'd10});
    add_row(stip_pkg::BASE_DEC, "^-2147483649", 0, 1'b1,
            stip_pkg::out_word_t'{stip_pkg::VALUE_HALF, 1'b1, 1'b1, 16'd11});
    add_row(stip_pkg::BASE_DEC, "^ \011\012\013\014\015+0019.", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_DEC, "55", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_DEC, "^-12^34z", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_DEC, "^abc", 0, 1'b1,
            stip_pkg::out_word_t'{32'sd0, 1'b0, 1'b0, 16'd0});
    add_row(stip_pkg::BASE_DEC, "^19", FILL_DIGITS, 1'b1,
            stip_pkg::out_word_t'{stip_pkg::VALUE_MAX, 1'b1, 1'b1, 16'd42});
    add_row(stip_pkg::BASE_DEC, "^-99999999999999 ", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_AUTO, "^0x1fFg", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_AUTO, "^07779", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_AUTO, "^0xg", 0, 1'b1,
            stip_pkg::out_word_t'{32'sd0, 1'b0, 1'b0, 16'd0});
    add_row(stip_pkg::BASE_AUTO, "^-0", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_AUTO, "^123a", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_HEX, "^0XdeadBEEF", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_HEX, "^0ag", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_HEX, "^-0x80000000", 0, 1'b1,
            stip_pkg::out_word_t'{stip_pkg::VALUE_HALF, 1'b0, 1'b1, 16'd11});
    add_row(6'd36, "^zZ09{", 0, 1'b0, '0);
    add_row(6'd1, "^00001", 0, 1'b0, '0);
    add_row(6'd63, "^Zz9@", 0, 1'b0, '0);
    add_row(6'd2, "^+101\377", 0, 1'b0, '0);
    add_row(stip_pkg::BASE_OCT, "^-17\200", 0, 1'b0, '0);
    add_row(6'd37, "^Zz[\140/:", 0, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.base != base_setting) write_base(row.base);
      flag_next = 1'b0;
      for (int i = 0; i < row.text.len(); i++) begin
        if (row.text[i] == CH_MARK) begin
          flag_next = 1'b1;
        end else begin
          send_char(flag_next, row.text[i], row.typed, row.want);
          flag_next = 1'b0;
        end
      end
      if (row.fill > 0) burst_left = row.fill + 1;
      repeat (row.fill) send_char(1'b0, row.text[row.text.len() - 1], row.typed, row.want);
      send_char(1'b0, CH_NUL, row.typed, row.want);
    end

    foreach (phase_bases[p]) begin
      write_base(phase_bases[p]);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) random_string();
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/stip_pkg.sv
rtl/string_to_integer_parser.sv
rtl/stip_checker.sv
dv/string_to_integer_parser_test.sv
